@@ rtl/length_prefixed_packet_deframer_defines.svh @@
// ---------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define LPPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lppd_pkg.sv @@
// ---------------------------------------------------------------------------
// Deframer package
// Item types, status codes and framing constants.
// ---------------------------------------------------------------------------
package lppd_pkg;

	localparam logic       OP_DATA       = 1'b0;
	localparam logic       OP_CONN_START = 1'b1;

	localparam logic [7:0] START_SHORT = 8'hC1;
	localparam logic [7:0] START_LONG  = 8'hC2;

	localparam logic [15:0] MIN_SIZE_SHORT = 16'd3;
	localparam logic [15:0] MIN_SIZE_LONG  = 16'd4;
	localparam logic [15:0] HEAD_POS_SHORT = 16'd3;
	localparam logic [15:0] HEAD_POS_LONG  = 16'd4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID      = 1'd1;

	localparam logic [15:0] MAX_SIZE_RESET   = 16'd8192;
	localparam logic [7:0]  CHANNEL_ID_RESET = 8'd0;

	typedef enum logic [1:0] {
		ST_BYTE      = 2'd0,
		ST_BAD_START = 2'd1,
		ST_BAD_SIZE  = 2'd2,
		ST_ABORT     = 2'd3
	} status_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       is_first;
		logic       is_head;
		logic       is_last;
		logic [7:0] channel;
	} out_item_t;

	typedef struct packed {
		logic [15:0] max_packet_size;
		logic [7:0]  channel_id;
	} cfg_t;

	typedef struct packed {
		logic      valid;
		out_item_t item;
	} frm_res_t;

endpackage

@@ rtl/lppd_stream_if.sv @@
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of a given payload type.
// ---------------------------------------------------------------------------
interface lppd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lppd_framer.sv @@
// ---------------------------------------------------------------------------
// Deframer core
// Framing state and per-item next-state and result logic.
// ---------------------------------------------------------------------------
`include "length_prefixed_packet_deframer_defines.svh"

module lppd_framer
	import lppd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	input  cfg_t     cfg,
	output frm_res_t res
);

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SIZE_HI = 2'd1,
		PH_SIZE_LO = 2'd2,
		PH_BODY    = 2'd3
	} phase_t;

	phase_t      phase_q, phase_d;
	logic        long_q, long_d;
	logic [15:0] size_q, size_d;
	logic [15:0] count_q, count_d;
	logic        halted_q, halted_d;

	logic [15:0] size_full;
	logic [15:0] min_size;
	logic [15:0] count_inc;
	logic [15:0] head_pos;

	assign size_full = {size_q[15:8], item.rx_byte};
	assign min_size  = long_q ? MIN_SIZE_LONG : MIN_SIZE_SHORT;
	assign head_pos  = long_q ? HEAD_POS_LONG : HEAD_POS_SHORT;
	assign count_inc = count_q + 16'd1;

	always_comb begin
		phase_d  = phase_q;
		long_d   = long_q;
		size_d   = size_q;
		count_d  = count_q;
		halted_d = halted_q;
		res                = '0;
		res.item.status    = ST_BYTE;
		res.item.channel   = cfg.channel_id;
		if (item.opcode == OP_CONN_START) begin
			phase_d  = PH_IDLE;
			long_d   = 1'b0;
			size_d   = '0;
			count_d  = '0;
			halted_d = 1'b0;
			if (phase_q != PH_IDLE) begin
				res.valid       = 1'b1;
				res.item.status = ST_ABORT;
			end
		end else if (!halted_q) begin
			res.valid         = 1'b1;
			res.item.out_byte = item.rx_byte;
			case (phase_q)
				PH_IDLE: begin
					if (item.rx_byte == START_SHORT || item.rx_byte == START_LONG) begin
						long_d            = (item.rx_byte == START_LONG);
						size_d            = '0;
						count_d           = 16'd1;
						phase_d           = (item.rx_byte == START_LONG) ? PH_SIZE_HI : PH_SIZE_LO;
						res.item.is_first = 1'b1;
					end else begin
						long_d            = 1'b0;
						size_d            = '0;
						count_d           = '0;
						halted_d          = 1'b1;
						res.item.out_byte = '0;
						res.item.status   = ST_BAD_START;
					end
				end
				PH_SIZE_HI: begin
					size_d  = {item.rx_byte, 8'h00};
					count_d = count_inc;
					phase_d = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					if (size_full < min_size || size_full > cfg.max_packet_size) begin
						phase_d           = PH_IDLE;
						long_d            = 1'b0;
						size_d            = '0;
						count_d           = '0;
						halted_d          = 1'b1;
						res.item.out_byte = '0;
						res.item.status   = ST_BAD_SIZE;
					end else begin
						size_d  = size_full;
						count_d = count_inc;
						phase_d = PH_BODY;
					end
				end
				default: begin
					res.item.is_head = (count_inc == head_pos);
					res.item.is_last = (count_inc >= size_q);
					if (count_inc >= size_q) begin
						phase_d = PH_IDLE;
						long_d  = 1'b0;
						size_d  = '0;
						count_d = '0;
					end else begin
						count_d = count_inc;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			long_q   <= 1'b0;
			size_q   <= '0;
			count_q  <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			long_q   <= long_d;
			size_q   <= size_d;
			count_q  <= count_d;
			halted_q <= halted_d;
		end
	end

	`LPPD_ASSERT_IMP(a_halt_idle, clk, arst_n, halted_q, phase_q == PH_IDLE, "halted outside idle phase")
	`LPPD_ASSERT_IMP(a_status_clean, clk, arst_n, res.valid && res.item.status != ST_BYTE, res.item.out_byte == 8'd0 && !res.item.is_first && !res.item.is_head && !res.item.is_last, "status result carries byte marks")
	`LPPD_ASSERT_NXT(a_conn_clear, clk, arst_n, step && item.opcode == OP_CONN_START, phase_q == PH_IDLE && !halted_q && count_q == 16'd0, "connection start did not clear state")
	`LPPD_ASSERT_IMP(a_first_idle, clk, arst_n, res.valid && res.item.is_first, phase_q == PH_IDLE && !halted_q, "start mark outside idle phase")

endmodule

@@ rtl/length_prefixed_packet_deframer.sv @@
// ---------------------------------------------------------------------------
// Length-prefixed packet deframer
// Frames 0xC1/0xC2 length-prefixed packets from a received byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per received byte (opcode 0) or connection start (1).
//   out_ch : packet bytes with first/head/last marks, or one status item
//            on a bad start byte, bad size or aborted packet.
//   cfg    : cfg_we/cfg_index/cfg_wdata, write only while the block is idle.
// Path: input register, framing update, result register driving out_ch.
// Throughput: one item per cycle while out_ch accepts; the framing state
//   takes one update per item between the input and result registers.
// Items that give no result (halted bytes, idle connection start) still
//   pass the stage and leave the result register empty.
// Reset: framing state clears to waiting for a start byte, not halted;
//   max_packet_size returns to 8192 and channel_id to 0.
// Stall: with out_ch held, the result register and the input register
//   both fill, after which in_ch.ready drops until out_ch is drained.
// ---------------------------------------------------------------------------
module length_prefixed_packet_deframer
	import lppd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lppd_stream_if.sink           in_ch,
	lppd_stream_if.source         out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      advance;
	frm_res_t  res;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_packet_size <= MAX_SIZE_RESET;
			cfg_q.channel_id      <= CHANNEL_ID_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PACKET_SIZE: cfg_q.max_packet_size <= cfg_wdata;
				REG_CHANNEL_ID:      cfg_q.channel_id      <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	lppd_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_item_q <= res.item;
		end
	end

endmodule

@@ dv/length_prefixed_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Length-prefixed packet deframer testbench
// Drives byte and connection-start items into the deframer and predicts
// every passed byte, mark and status item. Runs a short directed set, then
// random framed traffic with broken packets and noise, over several
// register settings, with random idling on both channels (but in one
// gap-free run) and one long output hold-off.
// ---------------------------------------------------------------------------
module length_prefixed_packet_deframer_tb;
	import lppd_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SIZE_HI = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_BODY    = 3'd3
	} frame_phase_t;

	class frame_tracker;
		logic [15:0]  max_size;
		logic [7:0]   chan;
		frame_phase_t ph;
		bit           long_form;
		logic [15:0]  pkt_size;
		logic [15:0]  byte_cnt;
		bit           halted;
		out_item_t    expected_bytes[$];
		int           errors;

		function new();
			max_size = MAX_SIZE_RESET;
			chan = CHANNEL_ID_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			ph = PH_IDLE;
			long_form = 1'b0;
			pkt_size = '0;
			byte_cnt = '0;
			halted = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_MAX_PACKET_SIZE) begin
				max_size = val;
			end else if (idx == REG_CHANNEL_ID) begin
				chan = val[7:0];
			end
		endfunction

		function void add(logic [7:0] b, status_t st, bit f, bit h, bit l);
			out_item_t r;
			r.out_byte = b;
			r.status = st;
			r.is_first = f;
			r.is_head = h;
			r.is_last = l;
			r.channel = chan;
			expected_bytes.push_back(r);
		endfunction

		function void accept_item(in_item_t it);
			bit          was_open;
			bit          at_last;
			logic [15:0] min_size;
			logic [7:0]  b;
			b = it.rx_byte;
			if (it.opcode == OP_CONN_START) begin
				was_open = (ph != PH_IDLE);
				clear();
				if (was_open)
					add(8'h00, ST_ABORT, 1'b0, 1'b0, 1'b0);
				return;
			end
			if (halted)
				return;
			case (ph)
			PH_IDLE: begin
				if (b == START_SHORT || b == START_LONG) begin
					long_form = (b == START_LONG);
					pkt_size = '0;
					byte_cnt = 16'd1;
					ph = long_form ? PH_SIZE_HI : PH_SIZE_LO;
					add(b, ST_BYTE, 1'b1, 1'b0, 1'b0);
				end else begin
					clear();
					halted = 1'b1;
					add(8'h00, ST_BAD_START, 1'b0, 1'b0, 1'b0);
				end
			end
			PH_SIZE_HI: begin
				pkt_size = {b, 8'h00};
				byte_cnt = byte_cnt + 16'd1;
				ph = PH_SIZE_LO;
				add(b, ST_BYTE, 1'b0, 1'b0, 1'b0);
			end
			PH_SIZE_LO: begin
				pkt_size = pkt_size | {8'h00, b};
				min_size = long_form ? MIN_SIZE_LONG : MIN_SIZE_SHORT;
				if (pkt_size < min_size || pkt_size > max_size) begin
					clear();
					halted = 1'b1;
					add(8'h00, ST_BAD_SIZE, 1'b0, 1'b0, 1'b0);
				end else begin
					byte_cnt = byte_cnt + 16'd1;
					ph = PH_BODY;
					add(b, ST_BYTE, 1'b0, 1'b0, 1'b0);
				end
			end
			default: begin
				byte_cnt = byte_cnt + 16'd1;
				at_last = (byte_cnt >= pkt_size);
				add(b, ST_BYTE, 1'b0,
					byte_cnt == (long_form ? HEAD_POS_LONG : HEAD_POS_SHORT), at_last);
				if (at_last)
					clear();
			end
			endcase
		endfunction

		function void compare(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, what, want, got);
				errors++;
			end
		endfunction

		function void check_item(out_item_t got);
			out_item_t want;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected item, byte 0x%0h status %0d",
					$time, got.out_byte, got.status);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			compare("out_byte", want.out_byte, got.out_byte);
			compare("status", want.status, got.status);
			compare("is_first", want.is_first, got.is_first);
			compare("is_head", want.is_head, got.is_head);
			compare("is_last", want.is_last, got.is_last);
			compare("channel", want.channel, got.channel);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_MAX_PACKET_SIZE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	lppd_stream_if #(.payload_t(in_item_t))  in_ch ();
	lppd_stream_if #(.payload_t(out_item_t)) out_ch ();

	length_prefixed_packet_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	frame_tracker fp;
	bit           no_gaps = 1'b0;
	bit           hold_req = 1'b0;
	int           items_sent = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (no_gaps) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 35);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			fp.check_item(out_ch.data);
	end

	task automatic push_item(input logic op, input logic [7:0] b);
		in_item_t it;
		it.opcode = op;
		it.rx_byte = b;
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		if (op == OP_CONN_START || !fp.halted)
			items_sent++;
		fp.accept_item(it);
		if (!no_gaps && $urandom_range(99) < 35) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 35);
		end
	endtask

	task automatic write_regs(input logic [15:0] max_size, input logic [7:0] chan);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_PACKET_SIZE;
		cfg_wdata <= max_size;
		@(posedge clk);
		fp.set_reg(REG_MAX_PACKET_SIZE, max_size);
		cfg_index <= REG_CHANNEL_ID;
		cfg_wdata <= {8'h00, chan};
		@(posedge clk);
		fp.set_reg(REG_CHANNEL_ID, {8'h00, chan});
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		int guard;
		guard = 0;
		in_ch.valid <= 1'b0;
		while (fp.expected_bytes.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// sends the first keep bytes of a packet of total size sz (all when keep is 0)
	task automatic send_frame(input bit lf, input int sz, input int keep);
		int n;
		int idx;
		n = (keep == 0) ? sz : keep;
		for (idx = 0; idx < n; idx++) begin
			if (idx == 0)
				push_item(OP_DATA, lf ? START_LONG : START_SHORT);
			else if (lf && idx == 1)
				push_item(OP_DATA, sz[15:8]);
			else if (idx == (lf ? 2 : 1))
				push_item(OP_DATA, sz[7:0]);
			else
				push_item(OP_DATA, 8'($urandom_range(255)));
		end
	endtask

	function automatic int pick_size(input bit lf);
		int lo;
		int hi;
		int r;
		lo = int'(lf ? MIN_SIZE_LONG : MIN_SIZE_SHORT);
		hi = int'(fp.max_size);
		if (!lf && hi > 255)
			hi = 255;
		if (hi < lo)
			return lo;
		r = $urandom_range(99);
		if (r < 10 && hi <= 300)
			return hi;
		if (r < 20)
			return $urandom_range(lo, (hi < 300) ? hi : 300);
		return $urandom_range(lo, (hi < lo + 12) ? hi : lo + 12);
	endfunction

	task automatic random_traffic(input int count);
		int         stop_at;
		int         pick;
		int         sz;
		int         lo;
		bit         lf;
		logic [7:0] b;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			lf = 1'($urandom_range(1));
			lo = int'(lf ? MIN_SIZE_LONG : MIN_SIZE_SHORT);
			if (pick < 70) begin
				send_frame(lf, pick_size(lf), 0);
			end else if (pick < 80) begin
				sz = pick_size(lf);
				send_frame(lf, sz, $urandom_range(1, sz - 1));
				push_item(OP_CONN_START, 8'($urandom_range(255)));
			end else if (pick < 88) begin
				if ($urandom_range(1) || fp.max_size == 16'hFFFF) begin
					sz = $urandom_range(lo - 1);
				end else begin
					sz = $urandom_range(int'(fp.max_size) + 1, 65535);
					if (sz > 255)
						lf = 1'b1;
				end
				send_frame(lf, sz, lf ? 3 : 2);
			end else if (pick < 94) begin
				do b = 8'($urandom_range(255)); while (b == START_SHORT || b == START_LONG);
				push_item(OP_DATA, b);
			end else if (pick < 97) begin
				push_item(OP_CONN_START, 8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 3)) push_item(OP_DATA, 8'($urandom_range(255)));
			end
			// get back to a clean frame boundary
			if (fp.halted) begin
				repeat ($urandom_range(3)) push_item(OP_DATA, 8'($urandom_range(255)));
				push_item(OP_CONN_START, 8'($urandom_range(255)));
			end else if (fp.ph != PH_IDLE) begin
				push_item(OP_CONN_START, 8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		fp = new();
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset register values
		push_item(OP_CONN_START, 8'h00);
		push_item(OP_DATA, START_SHORT);
		push_item(OP_DATA, 8'h03);
		push_item(OP_DATA, 8'h7E);
		push_item(OP_DATA, START_LONG);
		push_item(OP_DATA, 8'h00);
		push_item(OP_DATA, 8'h04);
		push_item(OP_DATA, 8'h5A);
		push_item(OP_DATA, START_SHORT);
		push_item(OP_DATA, 8'h05);
		push_item(OP_DATA, 8'h00);
		push_item(OP_DATA, 8'hFF);
		push_item(OP_DATA, 8'h80);
		push_item(OP_DATA, START_SHORT);
		push_item(OP_DATA, 8'h06);
		push_item(OP_DATA, 8'h11);
		push_item(OP_CONN_START, 8'hFF);
		push_item(OP_DATA, 8'h00);
		push_item(OP_DATA, START_SHORT);
		push_item(OP_CONN_START, 8'h00);
		push_item(OP_DATA, START_SHORT);
		push_item(OP_DATA, 8'h02);
		push_item(OP_CONN_START, 8'h00);
		push_item(OP_DATA, START_LONG);
		push_item(OP_DATA, 8'h20);
		push_item(OP_DATA, 8'h01);
		push_item(OP_CONN_START, 8'h00);
		wait_idle();

		write_regs(16'hFFFF, 8'hFF);
		no_gaps = 1'b1;
		random_traffic(150);
		wait_idle();
		no_gaps = 1'b0;

		write_regs(16'd4, 8'h00);
		random_traffic(130);
		wait_idle();

		write_regs(MAX_SIZE_RESET, 8'($urandom_range(255)));
		hold_req = 1'b1;
		random_traffic(150);
		wait_idle();

		write_regs(16'($urandom_range(4, 40)), 8'($urandom_range(255)));
		random_traffic(150);
		wait_idle();

		write_regs(16'd255, 8'($urandom_range(255)));
		random_traffic(130);
		wait_idle();

		if (fp.expected_bytes.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time,
				fp.expected_bytes.size());
			fp.errors++;
		end
		if (fp.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
